### design/drtr_pkg.sv
`default_nettype none

package drtr_pkg;

   // result queue geometry
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // result status codes
   localparam logic [1:0] ST_BYTE  = 2'd0;
   localparam logic [1:0] ST_CLOSE = 2'd1;
   localparam logic [1:0] ST_ERROR = 2'd2;

   // text kind codes
   localparam logic [1:0] KIND_PATTERN = 2'd0;
   localparam logic [1:0] KIND_REPL    = 2'd1;
   localparam logic [1:0] KIND_TRANS   = 2'd2;

   // one result item
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] status;
      logic       last;
   } res_type;

   // everything one script byte produces: zero, one or two results
   typedef struct packed {
      logic [1:0] count;
      res_type    first;
      res_type    second;
   } step_type;

endpackage : drtr_pkg

`default_nettype wire

### design/delimited_regex_text_reader.sv
`default_nettype none

// Reads one delimited string of a sed script, one byte per item, and returns the
// rewritten string as a stream of result items: a byte, the closing delimiter
// mark, or an unterminated-string error. An item passes the input register,
// then the scan logic writes its results into the result queue. A new item is
// taken every cycle while the queue has room for a pair, and results drain at
// one per cycle while rsp_stall is low; an item that yields two results (kept
// escape or re-escaped delimiter) pushes two entries while the single read port
// of the four-entry result queue pops one. Delimiter (reset '/') and text kind
// (0 regex, 1 replacement, 2 translation) sit at byte addresses 0 and 4 and are
// to be written only while the block is idle.
module delimited_regex_text_reader (
   input  wire logic        clock,
   input  wire logic        reset,
   // input items
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   // result items
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_status,
   output logic             rsp_last,
   // register port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import drtr_pkg::*;

   localparam logic       REG_DELIMITER = 1'b0;
   localparam logic       REG_TEXT_KIND = 1'b1;
   localparam logic [7:0] DELIM_RESET   = 8'd47;
   localparam logic [1:0] KIND_RESET    = KIND_PATTERN;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic [7:0] delimiter_ff;
   logic [1:0] text_kind_ff;
   logic       advance;
   logic       load;
   logic       fifo_room;
   logic       csr_write;
   step_type   step;
   res_type    head;

   // register port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      unique case (csr_paddr[2])
         REG_DELIMITER: csr_prdata = {24'd0, delimiter_ff};
         REG_TEXT_KIND: csr_prdata = {30'd0, text_kind_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delimiter_ff <= DELIM_RESET;
         text_kind_ff <= KIND_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            REG_DELIMITER: delimiter_ff <= csr_pwdata[7:0];
            REG_TEXT_KIND: text_kind_ff <= csr_pwdata[1:0];
         endcase
      end
   end

   // input register: held item moves on once the queue can take a pair
   assign advance     = in_valid_ff && fifo_room;
   assign req_stall   = in_valid_ff && !fifo_room;
   assign load        = req_valid && !req_stall;
   assign in_valid_in = load || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         in_byte_ff <= req_in_byte;
      end
   end

   drtr_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .step_byte (in_byte_ff),
      .delimiter (delimiter_ff),
      .text_kind (text_kind_ff),
      .step_out  (step)
   );

   drtr_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_en   (advance),
      .push_step (step),
      .pop       (rsp_valid && !rsp_stall),
      .room      (fifo_room),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_out_byte = head.data;
   assign rsp_status   = head.status;
   assign rsp_last     = head.last;

endmodule : delimited_regex_text_reader

`default_nettype wire

### design/drtr_scan.sv
`default_nettype none

module drtr_scan (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step_en,
   input  wire logic [7:0]        step_byte,
   input  wire logic [7:0]        delimiter,
   input  wire logic [1:0]        text_kind,
   output drtr_pkg::step_type     step_out
);
   import drtr_pkg::*;

   // scan modes
   localparam logic [2:0] MODE_PLAIN     = 3'd0;
   localparam logic [2:0] MODE_ESC       = 3'd1;
   localparam logic [2:0] MODE_BR_START  = 3'd2;
   localparam logic [2:0] MODE_BR_NEG    = 3'd3;
   localparam logic [2:0] MODE_BR_BODY   = 3'd4;
   localparam logic [2:0] MODE_BR_OPEN   = 3'd5;
   localparam logic [2:0] MODE_CLASS     = 3'd6;
   localparam logic [2:0] MODE_CLASS_END = 3'd7;

   // class element openers
   localparam logic [1:0] OPEN_NONE  = 2'd0;
   localparam logic [1:0] OPEN_COLON = 2'd1;
   localparam logic [1:0] OPEN_EQUAL = 2'd2;
   localparam logic [1:0] OPEN_DOT   = 2'd3;

   // characters of interest
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_EQUAL = 8'h3D;
   localparam logic [7:0] CH_LBR   = 8'h5B;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_RBR   = 8'h5D;
   localparam logic [7:0] CH_CARET = 8'h5E;
   localparam logic [7:0] CH_N     = 8'h6E;
   localparam logic [7:0] CH_T     = 8'h74;

   // bytes with a meaning of their own in regex syntax
   function automatic logic is_special(input logic [7:0] b);
      unique case (b)
         8'h2E, 8'h5B, 8'h5D, 8'h2A, 8'h5E, 8'h24, 8'h5C,
         8'h2B, 8'h3F, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h7C: is_special = 1'b1;
         default:                                          is_special = 1'b0;
      endcase
   endfunction

   // next mode inside a bracket body
   function automatic logic [2:0] body_mode(input logic [7:0] b);
      priority if (b == CH_RBR) begin
         body_mode = MODE_PLAIN;
      end else if (b == CH_LBR) begin
         body_mode = MODE_BR_OPEN;
      end else begin
         body_mode = MODE_BR_BODY;
      end
   endfunction

   logic [2:0] mode_ff, mode_in;
   logic [1:0] opener_ff, opener_in;
   logic [7:0] opener_char;
   logic [7:0] d0, d1;
   logic [1:0] s0;
   logic [1:0] cnt;
   logic       err;
   logic       esc_special;
   logic [2:0] class_mode;

   // character that closes the current class element
   always_comb begin
      unique case (opener_ff)
         OPEN_NONE:  opener_char = CH_NUL;
         OPEN_COLON: opener_char = CH_COLON;
         OPEN_EQUAL: opener_char = CH_EQUAL;
         OPEN_DOT:   opener_char = CH_DOT;
      endcase
   end

   assign class_mode  = (step_byte == opener_char) ? MODE_CLASS_END : MODE_CLASS;
   assign esc_special = ((text_kind == KIND_PATTERN) && is_special(step_byte)) ||
                        ((text_kind == KIND_REPL) && (step_byte == CH_AMP));
   // after a backslash only NUL is fatal; elsewhere NUL and newline are
   assign err = (mode_ff == MODE_ESC) ? (step_byte == CH_NUL)
                                      : ((step_byte == CH_NUL) || (step_byte == CH_NL));

   // decide the results and next mode for this byte
   always_comb begin
      mode_in   = mode_ff;
      opener_in = opener_ff;
      cnt       = 2'd1;
      d0        = step_byte;
      d1        = step_byte;
      s0        = ST_BYTE;
      if (err) begin
         d0        = CH_NUL;
         s0        = ST_ERROR;
         mode_in   = MODE_PLAIN;
         opener_in = OPEN_NONE;
      end else begin
         unique case (mode_ff)
            MODE_PLAIN: begin
               priority if (step_byte == delimiter) begin
                  d0 = CH_NUL;
                  s0 = ST_CLOSE;
               end else if (step_byte == CH_BSL) begin
                  cnt     = 2'd0;
                  mode_in = MODE_ESC;
               end else if ((step_byte == CH_LBR) && (text_kind == KIND_PATTERN)) begin
                  mode_in = MODE_BR_START;
               end else begin
                  cnt = 2'd1;
               end
            end
            MODE_ESC: begin
               mode_in = MODE_PLAIN;
               priority if (step_byte == delimiter) begin
                  if (esc_special) begin
                     cnt = 2'd2;
                     d0  = CH_BSL;
                  end
               end else if ((step_byte == CH_N) || (step_byte == CH_NL)) begin
                  d0 = CH_NL;
               end else if (step_byte == CH_T) begin
                  d0 = CH_TAB;
               end else if (text_kind == KIND_TRANS) begin
                  cnt = 2'd1;
               end else begin
                  cnt = 2'd2;
                  d0  = CH_BSL;
               end
            end
            MODE_BR_START: begin
               priority if ((step_byte == CH_CARET) || (step_byte == CH_BANG)) begin
                  mode_in = MODE_BR_NEG;
               end else if (step_byte == CH_RBR) begin
                  mode_in = MODE_BR_BODY;
               end else begin
                  mode_in = body_mode(step_byte);
               end
            end
            MODE_BR_NEG: begin
               mode_in = (step_byte == CH_RBR) ? MODE_BR_BODY : body_mode(step_byte);
            end
            MODE_BR_BODY: begin
               mode_in = body_mode(step_byte);
            end
            MODE_BR_OPEN: begin
               priority if (step_byte == CH_COLON) begin
                  mode_in   = MODE_CLASS;
                  opener_in = OPEN_COLON;
               end else if (step_byte == CH_EQUAL) begin
                  mode_in   = MODE_CLASS;
                  opener_in = OPEN_EQUAL;
               end else if (step_byte == CH_DOT) begin
                  mode_in   = MODE_CLASS;
                  opener_in = OPEN_DOT;
               end else begin
                  mode_in = body_mode(step_byte);
               end
            end
            MODE_CLASS: begin
               mode_in = class_mode;
            end
            MODE_CLASS_END: begin
               if (step_byte == CH_RBR) begin
                  mode_in   = MODE_BR_BODY;
                  opener_in = OPEN_NONE;
               end else begin
                  mode_in = class_mode;
               end
            end
         endcase
      end
   end

   // pack results; the final one carries last
   always_comb begin
      step_out.count         = cnt;
      step_out.first.data    = d0;
      step_out.first.status  = s0;
      step_out.first.last    = (cnt == 2'd1);
      step_out.second.data   = d1;
      step_out.second.status = ST_BYTE;
      step_out.second.last   = 1'b1;
   end

   // scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         opener_ff <= OPEN_NONE;
      end else if (step_en) begin
         mode_ff   <= mode_in;
         opener_ff <= opener_in;
      end
   end

`ifndef ASSERT_OFF
   // an opener is remembered exactly while inside a class element
   a_opener_in_class: assert property (@(posedge clock) disable iff (reset)
      ((mode_ff == MODE_CLASS) || (mode_ff == MODE_CLASS_END)) == (opener_ff != OPEN_NONE))
      else $error("class opener out of step with scan mode");

   // a pair of results is always two plain bytes
   a_pair_is_bytes: assert property (@(posedge clock) disable iff (reset)
      (step_en && (step_out.count == 2'd2)) |-> (step_out.first.status == ST_BYTE))
      else $error("two results with a non-byte status");
`endif

endmodule : drtr_scan

`default_nettype wire

### design/drtr_rsp_fifo.sv
`default_nettype none

module drtr_rsp_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push_en,
   input  drtr_pkg::step_type     push_step,
   input  wire logic              pop,
   output logic                   room,
   output logic                   not_empty,
   output drtr_pkg::res_type      head
);
   import drtr_pkg::*;

   localparam logic [RSP_CNT_W-1:0] ROOM_MAX = RSP_CNT_W'(RSP_DEPTH - 2);

   res_type                mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]   count_ff, count_in;
   logic [1:0]             push_cnt;
   logic [RSP_PTR_W-1:0]   wr_ptr_next;

   assign push_cnt    = push_en ? push_step.count : 2'd0;
   assign wr_ptr_next = wr_ptr_ff + RSP_PTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + RSP_PTR_W'(push_cnt);
   assign rd_ptr_in   = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in    = count_ff + RSP_CNT_W'(push_cnt) - RSP_CNT_W'(pop);

   // room for a full pair of results
   assign room      = (count_ff <= ROOM_MAX);
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_step.first;
      end
      if (push_cnt == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_step.second;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   // level never passes the depth
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("result queue overflow");

   // a push only lands when a pair still fits
   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (push_cnt != 2'd0) |-> room)
      else $error("push into a full result queue");
`endif

endmodule : drtr_rsp_fifo

`default_nettype wire
